// ===== rtl/cprb_pkg.sv =====
// ----------------------------------------------------------------------------
// cprb_pkg
// Shared types and constants for the command packet ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package cprb_pkg;

    // Default geometry of the ring
    localparam int SLOT_COUNT_DEF = 16;
    localparam int SLOT_BYTES_DEF = 10;

    // Fixed port geometry
    localparam int FIELD_BYTES = 10;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 8;
    localparam int COUNT_W     = 4;

    // Command codes
    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    // Control sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/command_packet_ring_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// command_packet_ring_buffer_unit
// Ring of packet slots with push and pop commands, one result per command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries a command, a length or
//   read limit and ten packet bytes. Output channel (o_out_valid /
//   i_out_stall) returns a count and ten bytes; bytes at or above the count
//   are zero.
//   A push with a length up to the slot size writes the slot memory in the
//   cycle it is taken, and its result is shown the next cycle.
//   A pop of a non-empty ring reads the slot memory into a register, then
//   cuts the packet in the ST_READ state, which stalls the input. A pop of
//   an empty ring returns a zero count without the read state.
//   The output register lets a new transaction be taken in the same cycle
//   the pending result leaves; while the receiver stalls a pending result,
//   the input is stalled as well.
//   Reset clears the pointers, the nonempty flag, the sequencer and the
//   output valid. Slot memory contents are not cleared; no read of an
//   unwritten slot can happen.
// ----------------------------------------------------------------------------
`default_nettype none

module command_packet_ring_buffer_unit
    import cprb_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_command,
    input  wire logic [LEN_W-1:0]   i_length_or_limit,
    input  wire logic [BYTE_W-1:0]  i_in_byte_0,
    input  wire logic [BYTE_W-1:0]  i_in_byte_1,
    input  wire logic [BYTE_W-1:0]  i_in_byte_2,
    input  wire logic [BYTE_W-1:0]  i_in_byte_3,
    input  wire logic [BYTE_W-1:0]  i_in_byte_4,
    input  wire logic [BYTE_W-1:0]  i_in_byte_5,
    input  wire logic [BYTE_W-1:0]  i_in_byte_6,
    input  wire logic [BYTE_W-1:0]  i_in_byte_7,
    input  wire logic [BYTE_W-1:0]  i_in_byte_8,
    input  wire logic [BYTE_W-1:0]  i_in_byte_9,

    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [COUNT_W-1:0]      o_count,
    output logic [BYTE_W-1:0]       o_out_byte_0,
    output logic [BYTE_W-1:0]       o_out_byte_1,
    output logic [BYTE_W-1:0]       o_out_byte_2,
    output logic [BYTE_W-1:0]       o_out_byte_3,
    output logic [BYTE_W-1:0]       o_out_byte_4,
    output logic [BYTE_W-1:0]       o_out_byte_5,
    output logic [BYTE_W-1:0]       o_out_byte_6,
    output logic [BYTE_W-1:0]       o_out_byte_7,
    output logic [BYTE_W-1:0]       o_out_byte_8,
    output logic [BYTE_W-1:0]       o_out_byte_9
);

    localparam int PTR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SLOT_COUNT - 1);
    localparam logic [COUNT_W-1:0] MAX_LEN = COUNT_W'(SLOT_BYTES);

    typedef logic [SLOT_BYTES-1:0][BYTE_W-1:0] t_row;

    // Slot memory: packet bytes and stored length
    t_row               mem_pkt [SLOT_COUNT];
    logic [COUNT_W-1:0] mem_len [SLOT_COUNT];

    // Control state
    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic               r_nonempty, n_nonempty;
    logic               r_out_valid, n_out_valid;

    // Payload state
    t_row               r_rd_pkt;
    logic [COUNT_W-1:0] r_rd_len;
    logic [COUNT_W-1:0] r_limit, n_limit;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [FIELD_BYTES-1:0][BYTE_W-1:0] r_bytes, n_bytes;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_push_ok;
    logic               w_pop_rd;
    logic [COUNT_W-1:0] w_pop_n;
    logic [PTR_W-1:0]   w_rd_next;
    logic [FIELD_BYTES-1:0][BYTE_W-1:0] w_in_bytes;
    logic [FIELD_BYTES-1:0][BYTE_W-1:0] w_pop_bytes;
    t_row               w_wr_row;

    // Gather input bytes
    assign w_in_bytes = {i_in_byte_9, i_in_byte_8, i_in_byte_7, i_in_byte_6,
                         i_in_byte_5, i_in_byte_4, i_in_byte_3, i_in_byte_2,
                         i_in_byte_1, i_in_byte_0};
    assign w_wr_row   = w_in_bytes[SLOT_BYTES-1:0];

    // Handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state == ST_READ) || !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_push_ok  = w_in_acc && (t_cmd'(i_command) == CMD_PUSH) &&
                        (i_length_or_limit <= LEN_W'(SLOT_BYTES));
    assign w_pop_rd   = w_in_acc && (t_cmd'(i_command) == CMD_POP) && r_nonempty;
    assign w_rd_next  = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;

    // Cut the fetched packet to the limit
    assign w_pop_n = (r_rd_len < r_limit) ? r_rd_len : r_limit;

    for (genvar k = 0; k < FIELD_BYTES; k++) begin : g_pop_bytes
        if (k < SLOT_BYTES) begin : g_live
            assign w_pop_bytes[k] = (COUNT_W'(k) < w_pop_n) ? r_rd_pkt[k] : '0;
        end else begin : g_zero
            assign w_pop_bytes[k] = '0;
        end
    end

    // Write the slot memory on an accepted push
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            mem_pkt[r_wr_ptr] <= w_wr_row;
            mem_len[r_wr_ptr] <= i_length_or_limit[COUNT_W-1:0];
        end
    end

    // Read the oldest slot on an accepted pop
    always_ff @(posedge i_clk) begin
        if (w_pop_rd) begin
            r_rd_pkt <= mem_pkt[r_rd_ptr];
            r_rd_len <= mem_len[r_rd_ptr];
        end
    end

    // Next state, pointers and result register
    always_comb begin
        n_state     = r_state;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_nonempty  = r_nonempty;
        n_limit     = r_limit;
        n_out_valid = r_out_valid && i_out_stall;
        n_count     = r_count;
        n_bytes     = r_bytes;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (t_cmd'(i_command) == CMD_PUSH) begin
                        n_out_valid = 1'b1;
                        n_bytes     = '0;
                        n_count     = '0;
                        if (w_push_ok) begin
                            n_count    = i_length_or_limit[COUNT_W-1:0];
                            n_nonempty = 1'b1;
                            n_wr_ptr   = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
                        end
                    end else if (r_nonempty) begin
                        n_state    = ST_READ;
                        n_limit    = (i_length_or_limit > LEN_W'(SLOT_BYTES)) ?
                                     MAX_LEN : i_length_or_limit[COUNT_W-1:0];
                        n_rd_ptr   = w_rd_next;
                        n_nonempty = (w_rd_next != r_wr_ptr);
                    end else begin
                        n_out_valid = 1'b1;
                        n_count     = '0;
                        n_bytes     = '0;
                    end
                end
            end
            ST_READ: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                n_count     = w_pop_n;
                n_bytes     = w_pop_bytes;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_nonempty  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_nonempty  <= n_nonempty;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_limit <= n_limit;
        r_count <= n_count;
        r_bytes <= n_bytes;
    end

    // Drive outputs
    assign o_out_valid  = r_out_valid;
    assign o_count      = r_count;
    assign o_out_byte_0 = r_bytes[0];
    assign o_out_byte_1 = r_bytes[1];
    assign o_out_byte_2 = r_bytes[2];
    assign o_out_byte_3 = r_bytes[3];
    assign o_out_byte_4 = r_bytes[4];
    assign o_out_byte_5 = r_bytes[5];
    assign o_out_byte_6 = r_bytes[6];
    assign o_out_byte_7 = r_bytes[7];
    assign o_out_byte_8 = r_bytes[8];
    assign o_out_byte_9 = r_bytes[9];

`ifndef SYNTHESIS
    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_state == ST_IDLE))
        else $error("pop read phase lasted more than one cycle");

    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !r_out_valid)
        else $error("pop result would overwrite a pending result");

    a_read_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> o_in_stall)
        else $error("transaction taken during pop read");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_nonempty |-> (r_rd_ptr == r_wr_ptr))
        else $error("ring empty but pointers differ");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_count <= MAX_LEN))
        else $error("result count above slot size");
`endif

endmodule

`default_nettype wire
